@@ hdl/ookrx_pkg.sv @@
// ----------------------------------------------------------------------------
// ookrx_pkg
// shared widths, register indexes and frame constants of the on-off-keying
// frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package ookrx_pkg;

    // field widths
    localparam int SAMPLE_W    = 10;
    localparam int THRESH_W    = 10;
    localparam int TICKS_W     = 16;
    localparam int CHAR_W      = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_TICKS       = 1'd1;

    // configuration reset values
    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd350;
    localparam logic [TICKS_W-1:0]  TICKS_RESET  = 16'd150;

    // frame layout
    localparam logic [7:0] END_MARK    = 8'hF0;
    localparam logic [3:0] MARK_LEN    = 4'd8;
    localparam logic [3:0] PAYLOAD_MIN = 4'd12;  // start mark plus end mark
    localparam logic [3:0] COUNT_MAX   = 4'd15;
    localparam logic [3:0] BYTE_BITS   = 4'd8;

    // one result item
    typedef struct packed {
        logic [CHAR_W-1:0] char_value;
        logic              char_valid;
        logic              message_end;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/optical_ook_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// optical_ook_frame_receiver
// recovers bytes from an on-off-keyed light signal, one sensor sample a tick
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  sample   | in        | i_in_valid / o_in_stall   | i_light_sample
//  result   | out       | o_out_valid / i_out_stall | o_char_value, o_char_valid,
//           |           |                           | o_message_end
//  config   | in        | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
//  one sample per clock while the result side does not stall; a sample waits
//  in the input register and its result is written to the result register
//  the per-sample work (threshold compare, tick counter, bit shifters) sits
//  between those two registers, so the rate is set by that single stage
//  a stalled result holds the result register; the input register keeps
//  taking samples until it holds one that cannot move forward
//  reset is synchronous, active low; thresholds return to 350 and 150 ticks
// ----------------------------------------------------------------------------
`default_nettype none

module optical_ook_frame_receiver (
    input  wire                              i_clk,
    input  wire                              i_rst_n,

    // configuration write port
    input  wire                              i_cfg_wr_en,
    input  wire [ookrx_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire [ookrx_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    // sample channel
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire [ookrx_pkg::SAMPLE_W-1:0]    i_light_sample,

    // result channel
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [ookrx_pkg::CHAR_W-1:0]     o_char_value,
    output logic                             o_char_valid,
    output logic                             o_message_end
);

    import ookrx_pkg::*;

    // configuration registers
    logic [THRESH_W-1:0] r_light_threshold;
    logic [TICKS_W-1:0]  r_bit_ticks;

    // input register
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_sample;

    // receiver state
    logic               r_last_level;    // 1 = dark
    logic [TICKS_W-1:0] r_steady_ticks;
    logic               r_receiving;
    logic [7:0]         r_recent_bits;   // last eight frame bits
    logic [3:0]         r_frame_count;   // frame bits seen, saturating
    logic [7:0]         r_pay_window;    // payload bits not yet emitted
    logic [3:0]         r_pay_fill;      // number of those bits

    // result register
    logic    r_out_valid;
    t_result r_result;

    // next values
    logic               n_last_level;
    logic [TICKS_W-1:0] n_steady_ticks;
    logic               n_receiving;
    logic [7:0]         n_recent_bits;
    logic [3:0]         n_frame_count;
    logic [7:0]         n_pay_window;
    logic [3:0]         n_pay_fill;
    logic               n_have_result;
    t_result            n_result;

    // handshake
    logic out_free;   // result register can take a new result
    logic fire;       // input register item is processed this cycle
    logic in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // per-sample logic
    // ------------------------------------------------------------------
    logic       level;
    logic       take_bit;
    logic       bit_val;
    logic       bit_go;
    logic       have_byte;
    logic [7:0] shifted_window;
    logic [3:0] fill_inc;
    logic       frame_end;

    always_comb begin
        // light (below threshold) is level 0
        level = (r_sample < r_light_threshold) ? 1'b0 : 1'b1;

        n_last_level = level;
        if (level != r_last_level) begin
            n_steady_ticks = '0;
        end else if (r_steady_ticks != {TICKS_W{1'b1}}) begin
            n_steady_ticks = r_steady_ticks + 1'b1;
        end else begin
            n_steady_ticks = r_steady_ticks;
        end

        // enough steady ticks: take a bit, restart the counter
        take_bit = (n_steady_ticks >= r_bit_ticks);
        if (take_bit) begin
            n_steady_ticks = '0;
        end

        // light starts a frame; dark only counts inside one
        bit_val = !level;
        bit_go  = take_bit && (!level || r_receiving);

        n_receiving    = r_receiving || (take_bit && !level);
        n_recent_bits  = r_recent_bits;
        n_frame_count  = r_frame_count;
        n_pay_window   = r_pay_window;
        n_pay_fill     = r_pay_fill;
        have_byte      = 1'b0;
        shifted_window = {r_pay_window[6:0], r_recent_bits[7]};
        fill_inc       = r_pay_fill + 1'b1;
        frame_end      = 1'b0;
        n_have_result  = 1'b0;
        n_result       = '{char_value: '0, char_valid: 1'b0, message_end: 1'b0};

        if (bit_go) begin
            // the bit leaving the mark window becomes payload once past the start mark
            if (r_frame_count >= PAYLOAD_MIN) begin
                if (fill_inc >= BYTE_BITS) begin
                    have_byte    = 1'b1;
                    n_pay_window = '0;
                    n_pay_fill   = '0;
                end else begin
                    n_pay_window = shifted_window;
                    n_pay_fill   = fill_inc;
                end
            end
            n_recent_bits = {r_recent_bits[6:0], bit_val};
            if (r_frame_count != COUNT_MAX) begin
                n_frame_count = r_frame_count + 1'b1;
            end

            frame_end = (n_frame_count >= MARK_LEN) && (n_recent_bits == END_MARK);

            if (frame_end) begin
                n_have_result = 1'b1;
                if (have_byte) begin
                    n_result.char_value = shifted_window;
                    n_result.char_valid = 1'b1;
                end else if (n_pay_fill != '0) begin
                    // trailing partial byte, plain binary value
                    n_result.char_value = n_pay_window;
                    n_result.char_valid = 1'b1;
                end
                n_result.message_end = 1'b1;
                // frame done, back to waiting for light
                n_receiving   = 1'b0;
                n_recent_bits = '0;
                n_frame_count = '0;
                n_pay_window  = '0;
                n_pay_fill    = '0;
            end else if (have_byte) begin
                n_have_result       = 1'b1;
                n_result.char_value = shifted_window;
                n_result.char_valid = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------

    // configuration, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_threshold <= THRESH_RESET;
            r_bit_ticks       <= TICKS_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LIGHT_THRESHOLD: r_light_threshold <= i_cfg_data[THRESH_W-1:0];
                CFG_BIT_TICKS:       r_bit_ticks       <= i_cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_light_sample;
        end
    end

    // receiver state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level   <= 1'b1;
            r_steady_ticks <= '0;
            r_receiving    <= 1'b0;
            r_recent_bits  <= '0;
            r_frame_count  <= '0;
            r_pay_window   <= '0;
            r_pay_fill     <= '0;
        end else if (fire) begin
            r_last_level   <= n_last_level;
            r_steady_ticks <= n_steady_ticks;
            r_receiving    <= n_receiving;
            r_recent_bits  <= n_recent_bits;
            r_frame_count  <= n_frame_count;
            r_pay_window   <= n_pay_window;
            r_pay_fill     <= n_pay_fill;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && n_have_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_have_result) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_char_value  = r_result.char_value;
    assign o_char_valid  = r_result.char_valid;
    assign o_message_end = r_result.message_end;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // outside a frame no frame bits are held
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_receiving |-> (r_frame_count == '0) && (r_pay_fill == '0))
        else $error("frame state left over while not receiving");

    // a full byte is always emitted, never kept
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pay_fill < BYTE_BITS)
        else $error("payload fill reached a full byte");

    // payload only collects once the start mark and the end-mark window have passed
    a_fill_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_count < PAYLOAD_MIN) |-> (r_pay_fill == '0))
        else $error("payload collected inside the start mark");

    // a produced result is presented on the next cycle
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_have_result) |=> r_out_valid)
        else $error("result lost on its way to the output");

    // the input side stalls only while holding a sample
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled without a blocked sample");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the on-off-keying frame receiver: sensor samples are
// streamed through the valid/stall channel and every byte and end-of-frame
// result is checked against a bit-level decoder kept inside the bench
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ookrx_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_TICKS = 9;
    localparam int SETTLE      = 8;          // cycles for samples still in the pipe
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;

    // how the two sides pause
    typedef enum int {
        PACE_SLOW_RECEIVER,   // sender idles 8 in 100, receiver stalls 61 in 100
        PACE_SLOW_SENDER,     // the other way round
        PACE_FULL_RATE        // nobody idles
    } t_pace;

    // dut ports
    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data     = '0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic [SAMPLE_W-1:0]    i_light_sample = '0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic [CHAR_W-1:0]      o_char_value;
    logic                   o_char_valid;
    logic                   o_message_end;

    optical_ook_frame_receiver u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_light_sample (i_light_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_char_value   (o_char_value),
        .o_char_valid   (o_char_valid),
        .o_message_end  (o_message_end)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // bench-side bookkeeping
    logic [SAMPLE_W-1:0] pending_samples[$];   // samples waiting for the driver
    t_result             expected_chars[$];    // results the decoder has predicted
    int                  queued_count   = 0;
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;
    logic                sample_taken   = 1'b0;
    t_pace               pace           = PACE_SLOW_RECEIVER;

    // generator's view of the current settings
    int gen_thresh = THRESH_RESET;
    int gen_ticks  = TICKS_RESET;

    // decoder copy of the configuration and the receive state
    logic [THRESH_W-1:0] dec_thresh  = THRESH_RESET;
    logic [TICKS_W-1:0]  dec_ticks   = TICKS_RESET;
    logic                dec_level   = 1'b1;      // dark
    logic [TICKS_W-1:0]  dec_steady  = '0;
    logic                dec_active  = 1'b0;
    logic [7:0]          dec_recent  = '0;        // last eight frame bits
    logic [3:0]          dec_count   = '0;        // frame bits, saturating
    logic [15:0]         dec_window  = '0;        // payload bits not yet emitted
    logic [4:0]          dec_fill    = '0;

    // ------------------------------------------------------------------------
    // decoder: one sensor sample in, zero or one expected result out
    // ------------------------------------------------------------------------
    task automatic decode_sample(input logic [SAMPLE_W-1:0] smp);
        logic       lvl;
        logic       bitv;
        logic       got_char;
        logic [7:0] char_v;
        t_result    res;
        lvl      = (smp < dec_thresh) ? 1'b0 : 1'b1;   // below threshold is light
        got_char = 1'b0;
        char_v   = '0;

        // steady-level tick counter, restarts on every level change
        if (lvl != dec_level) begin
            dec_level  = lvl;
            dec_steady = '0;
        end else if (dec_steady != '1) begin
            dec_steady = dec_steady + 1'b1;
        end
        if (dec_steady < dec_ticks) return;
        dec_steady = '0;

        // light always starts or continues a frame, dark only continues one
        if (lvl == 1'b0) begin
            dec_active = 1'b1;
            bitv       = 1'b1;
        end else if (dec_active) begin
            bitv = 1'b0;
        end else begin
            return;
        end

        // a bit becomes payload when it leaves the end-mark window past the start mark
        if (dec_count >= PAYLOAD_MIN) begin
            dec_window = {dec_window[14:0], dec_recent[7]};
            dec_fill   = dec_fill + 1'b1;
            if (dec_fill >= BYTE_BITS) begin
                got_char   = 1'b1;
                char_v     = dec_window[7:0];
                dec_window = '0;
                dec_fill   = '0;
            end
        end
        dec_recent = {dec_recent[6:0], bitv};
        if (dec_count != COUNT_MAX) dec_count = dec_count + 1'b1;

        if (dec_count >= MARK_LEN && dec_recent == END_MARK) begin
            // end of frame carries a just-finished byte, the partial byte, or nothing
            res.message_end = 1'b1;
            if (got_char) begin
                res.char_value = char_v;
                res.char_valid = 1'b1;
            end else if (dec_fill != '0) begin
                res.char_value = dec_window[7:0];
                res.char_valid = 1'b1;
            end else begin
                res.char_value = '0;
                res.char_valid = 1'b0;
            end
            expected_chars.push_back(res);
            dec_active = 1'b0;
            dec_recent = '0;
            dec_count  = '0;
            dec_window = '0;
            dec_fill   = '0;
            return;
        end

        if (got_char) begin
            res.char_value  = char_v;
            res.char_valid  = 1'b1;
            res.message_end = 1'b0;
            expected_chars.push_back(res);
        end
    endtask

    task automatic report_char_error(input string why, input t_result exp_r);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("char error (%s): expected value %02h valid %0b end %0b,",
                     why, exp_r.char_value, exp_r.char_valid, exp_r.message_end,
                     " got value %02h valid %0b end %0b",
                     o_char_value, o_char_valid, o_message_end);
    endtask

    // ------------------------------------------------------------------------
    // rising edge: watchdog, register capture, sample transfers, result checks
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_r;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            if (i_rst_n && i_cfg_wr_en) begin
                if (i_cfg_index == CFG_LIGHT_THRESHOLD)
                    dec_thresh = i_cfg_data[THRESH_W-1:0];
                else if (i_cfg_index == CFG_BIT_TICKS)
                    dec_ticks = i_cfg_data[TICKS_W-1:0];
            end

            // sample transfer
            sample_taken = i_rst_n && i_in_valid && !o_in_stall;
            if (sample_taken) decode_sample(i_light_sample);

            // result transfer
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    exp_r = '0;
                    report_char_error("nothing expected", exp_r);
                end else begin
                    exp_r = expected_chars.pop_front();
                    if (o_char_value !== exp_r.char_value ||
                        o_char_valid !== exp_r.char_valid ||
                        o_message_end !== exp_r.message_end)
                        report_char_error("field differs", exp_r);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // falling edge: sample driver and result stall
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        int send_pct;
        int stall_pct;
        case (pace)
            PACE_SLOW_RECEIVER: begin
                send_pct  = 8;
                stall_pct = 61;
            end
            PACE_SLOW_SENDER: begin
                send_pct  = 61;
                stall_pct = 8;
            end
            default: begin
                send_pct  = 0;
                stall_pct = 0;
            end
        endcase

        // a held sample stays put until its transfer
        if (!i_in_valid || sample_taken) begin
            if (pending_samples.size() != 0 && $urandom_range(99, 0) >= send_pct) begin
                i_in_valid     <= 1'b1;
                i_light_sample <= pending_samples.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_sample(input int value);
        pending_samples.push_back(SAMPLE_W'(value));
        queued_count++;
    endtask

    // n samples at one level; with a zero threshold nothing reads as light
    task automatic push_level(input logic dark, input int n);
        repeat (n) begin
            if (dark || gen_thresh == 0)
                push_sample($urandom_range(SAMPLE_MAX, gen_thresh));
            else
                push_sample($urandom_range(gen_thresh - 1, 0));
        end
    endtask

    // turn a bit string into level runs long enough for the tick counter,
    // optionally nudging a run by one sample to break the timing
    task automatic push_bits(input logic bits[$], input logic jitter);
        int i;
        int j;
        int n;
        i = 0;
        while (i < bits.size()) begin
            j = i;
            while (j < bits.size() && bits[j] == bits[i]) j++;
            n = (gen_ticks == 0) ? (j - i) : (j - i) * gen_ticks + 1;
            if (jitter && $urandom_range(15, 0) == 0)
                n = ($urandom_range(1, 0) != 0 || n == 1) ? n + 1 : n - 1;
            push_level(!bits[i], n);
            i = j;
        end
    endtask

    // frames with random payload, some cut short, plus raw noise
    task automatic queue_traffic(input int target);
        logic frame_bits[$];
        int   goal;
        int   kind;
        int   cut;
        goal = queued_count + target;
        while (queued_count < goal) begin
            kind = $urandom_range(99, 0);
            if (kind < 12) begin
                repeat ($urandom_range(20, 4)) push_sample($urandom_range(SAMPLE_MAX, 0));
            end else begin
                frame_bits.delete();
                repeat (4) frame_bits.push_back(1'b1);
                repeat (8 * $urandom_range(2, 0) + $urandom_range(7, 0))
                    frame_bits.push_back($urandom_range(1, 0) != 0);
                for (int k = 7; k >= 0; k--) frame_bits.push_back(END_MARK[k]);
                if (kind < 22) begin
                    // broken frame: leave the receiver mid-frame
                    cut = $urandom_range(frame_bits.size() - 2, 1);
                    while (frame_bits.size() > cut) void'(frame_bits.pop_back());
                end
                push_bits(frame_bits, 1'b1);
                push_level(1'b1, $urandom_range(8, 1));
            end
        end
    endtask

    // wait until every sample is through and every result has arrived
    task automatic drain;
        while (pending_samples.size() != 0 || i_in_valid || expected_chars.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reconfigure(input t_pace next_pace, input int thresh, input int ticks);
        drain();
        pace = next_pace;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_LIGHT_THRESHOLD;
        i_cfg_data  <= CFG_DATA_W'(thresh);
        @(negedge i_clk);
        i_cfg_index <= CFG_BIT_TICKS;
        i_cfg_data  <= CFG_DATA_W'(ticks);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        gen_thresh = thresh;
        gen_ticks  = ticks;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic frame_bits[$];
        repeat (RESET_TICKS) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one bit per tick so every sample is a frame bit
        reconfigure(PACE_SLOW_RECEIVER, 512, 0);
        // short frame, start mark straight into end mark: end with no payload
        push_sample(0);
        push_sample(200);
        push_sample(349);
        push_sample(511);
        push_sample(SAMPLE_MAX);
        push_sample(512);
        push_sample(900);
        push_sample(768);
        // one full byte finishing on the same bit as the end mark
        frame_bits = {1'b1, 1'b1, 1'b1, 1'b1,
                      1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        for (int k = 7; k >= 0; k--) frame_bits.push_back(END_MARK[k]);
        push_bits(frame_bits, 1'b0);

        // random traffic over several settings, threshold extremes included
        reconfigure(PACE_SLOW_RECEIVER, 350, 1);
        queue_traffic(170);
        reconfigure(PACE_SLOW_RECEIVER, 1023, 2);
        queue_traffic(130);
        reconfigure(PACE_SLOW_SENDER, 100, 0);
        queue_traffic(170);
        reconfigure(PACE_SLOW_SENDER, 0, 1);       // everything reads as dark
        queue_traffic(40);
        reconfigure(PACE_SLOW_SENDER, 700, 3);
        queue_traffic(170);
        reconfigure(PACE_FULL_RATE, 1, 1);         // only a zero reading is light
        queue_traffic(100);
        reconfigure(PACE_FULL_RATE, 600, 2);
        queue_traffic(200);

        drain();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ookrx_pkg.sv
hdl/optical_ook_frame_receiver.sv
tb/tb.sv
